>>> hw/rtl/abd_pkg.sv
package abd_pkg;

    localparam int IDX_W  = 21;
    localparam int SUM_W  = 37;
    localparam int MEAN_W = 24;
    localparam int DIVD_W = SUM_W + 8;
    localparam int DIVS_W = IDX_W;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_BOUT  = 2'd1;
    localparam logic [1:0] REG_DROP_TOL  = 2'd2;
    localparam logic [1:0] REG_PERCENT   = 2'd3;

    localparam logic KIND_BOUT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_res_t;

endpackage

>>> hw/rtl/abd_div.sv
module abd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [abd_pkg::DIVD_W-1:0] dividend,
    input  logic [abd_pkg::DIVS_W-1:0] divisor,
    output abd_pkg::div_res_t         res
);
    import abd_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] den_reg, den_next;
    logic [DIVS_W:0]   trial;
    logic              fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVS_W'(trial - {1'b0, den_reg}) : trial[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

>>> hw/rtl/activity_bout_detector_with_drops.sv
// channel  | dir | handshake                 | payload
// s_*      | in  | s_tvalid / s_tready       | s_tdata epoch_count, s_tuser epoch_missing,
//          |     |                           | s_tlast record_end
// m_*      | out | m_tvalid / m_tready       | m_tdata bout and total fields, m_tuser
//          |     |                           | record_kind, m_tlast last_of_run
// cfg_*    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// an epoch that closes no bout and ends no record is taken in ST_IDLE alone
// closing a bout or ending a record adds the ST_CHECK state
// a valid bout adds a pass of the bit-serial mean divider and one bout request
// a record end adds one summary request
// s_tready stays low until every result of the epoch has been taken at m_*
// rst_n clears all epoch and bout state and loads register defaults
module activity_bout_detector_with_drops #(
    parameter int MAX_EPOCHS = 1048576,
    parameter int COUNT_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // epoch_count
    input  logic [0:0]   s_tuser,   // epoch_missing
    input  logic         s_tlast,   // record_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // bout_first_epoch, bout_last_epoch, bout_span, bout_drop_epochs, bout_mean_count,
    // active_epoch_total, bout_time_total, valid_bout_total, zero fill
    output logic [175:0] m_tdata,
    output logic [0:0]   m_tuser,   // record_kind
    output logic         m_tlast,   // last_of_run
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import abd_pkg::*;

    localparam int CB = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam logic [15:0] COUNT_MASK = 16'((32'd1 << CB) - 32'd1);
    localparam logic [IDX_W-1:0] CNT_CAP =
        (MAX_EPOCHS < 2097151) ? IDX_W'(MAX_EPOCHS) : {IDX_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_BOUT,
        ST_SUM
    } state_t;

    function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] a);
        return (a >= CNT_CAP) ? CNT_CAP : a + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] sat_cnt(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W:0] b);
        logic [IDX_W+1:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {2'b0, CNT_CAP}) ? CNT_CAP : s[IDX_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [15:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [15:0]       thr_reg, thr_next;
    logic [15:0]       minb_reg, minb_next;
    logic [7:0]        tol_reg, tol_next;
    logic              pct_reg, pct_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              inside_reg, inside_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [IDX_W-1:0]  aib_reg, aib_next;
    logic [IDX_W-1:0]  span_reg, span_next;
    logic [IDX_W-1:0]  dal_reg, dal_next;
    logic [IDX_W-1:0]  rdrop_reg, rdrop_next;
    logic [7:0]        ci_reg, ci_next;
    logic [SUM_W-1:0]  sal_reg, sal_next;
    logic [SUM_W-1:0]  rsum_reg, rsum_next;
    logic [IDX_W-1:0]  atot_reg, atot_next;
    logic [IDX_W-1:0]  btime_reg, btime_next;
    logic [IDX_W-1:0]  bcnt_reg, bcnt_next;
    logic              close_reg, close_next;
    logic              rend_reg, rend_next;
    logic              mvalid_reg, mvalid_next;
    logic [175:0]      mdata_reg, mdata_next;
    logic              mkind_reg, mkind_next;
    logic              mlast_reg, mlast_next;

    logic [15:0]       cnt;
    logic              missing;
    logic              active;
    logic              in_acc;
    logic              bout_ok;
    logic [23:0]       act5;
    logic [23:0]       span4;
    logic [IDX_W+1:0]  last_raw;
    logic [IDX_W-1:0]  last_ep;
    logic [MEAN_W-1:0] mean;
    logic              div_start;
    div_res_t          div_res;

    abd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sal_reg, 8'd0}),
        .divisor  (span_reg),
        .res      (div_res)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign cnt       = s_tdata & COUNT_MASK;
    assign missing   = s_tuser[0];
    assign active    = !missing && (cnt >= thr_reg);

    assign act5     = ({3'b0, aib_reg} << 2) + {3'b0, aib_reg};
    assign span4    = {3'b0, span_reg} << 2;
    assign bout_ok  = close_reg && (aib_reg >= IDX_W'(minb_reg))
                      && !(pct_reg && (act5 < span4)) && (span_reg != '0);
    assign last_raw = {2'b0, start_reg} + {2'b0, span_reg} - (IDX_W+2)'(1);
    assign last_ep  = (last_raw > {2'b0, CNT_CAP}) ? CNT_CAP : last_raw[IDX_W-1:0];
    assign mean     = (|div_res.quotient[DIVD_W-1:MEAN_W]) ? {MEAN_W{1'b1}}
                                                           : div_res.quotient[MEAN_W-1:0];
    assign div_start = (state_reg == ST_CHECK) && bout_ok;

    always_comb
    begin
        state_next  = state_reg;
        thr_next    = thr_reg;
        minb_next   = minb_reg;
        tol_next    = tol_reg;
        pct_next    = pct_reg;
        idx_next    = idx_reg;
        inside_next = inside_reg;
        start_next  = start_reg;
        aib_next    = aib_reg;
        span_next   = span_reg;
        dal_next    = dal_reg;
        rdrop_next  = rdrop_reg;
        ci_next     = ci_reg;
        sal_next    = sal_reg;
        rsum_next   = rsum_reg;
        atot_next   = atot_reg;
        btime_next  = btime_reg;
        bcnt_next   = bcnt_reg;
        close_next  = close_reg;
        rend_next   = rend_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mkind_next  = mkind_reg;
        mlast_next  = mlast_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_next  = cfg_data;
                REG_MIN_BOUT:  minb_next = cfg_data;
                REG_DROP_TOL:  tol_next  = cfg_data[7:0];
                REG_PERCENT:   pct_next  = cfg_data[0];
                default:       thr_next  = thr_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next   = sat_inc(idx_reg);
                    close_next = 1'b0;
                    rend_next  = s_tlast;
                    if (active)
                        atot_next = sat_inc(atot_reg);
                    if (inside_reg)
                    begin
                        if (active)
                        begin
                            aib_next  = sat_inc(aib_reg);
                            span_next = sat_cnt(span_reg, {1'b0, IDX_W'(ci_reg)} + 22'd1);
                            rsum_next = sat_sum(rsum_reg, cnt);
                            sal_next  = sat_sum(rsum_reg, cnt);
                            dal_next  = rdrop_reg;
                            ci_next   = '0;
                        end
                        else if (ci_reg < tol_reg)
                        begin
                            ci_next    = ci_reg + 8'd1;
                            rdrop_next = sat_inc(rdrop_reg);
                            if (!missing)
                                rsum_next = sat_sum(rsum_reg, cnt);
                        end
                        else
                        begin
                            close_next = 1'b1;
                        end
                    end
                    else if (active)
                    begin
                        inside_next = 1'b1;
                        start_next  = sat_inc(idx_reg);
                        aib_next    = IDX_W'(1);
                        span_next   = IDX_W'(1);
                        dal_next    = '0;
                        rdrop_next  = '0;
                        ci_next     = '0;
                        rsum_next   = SUM_W'(cnt);
                        sal_next    = SUM_W'(cnt);
                    end
                    // record end closes the bout left open by this epoch
                    if (s_tlast && inside_reg && (active || ci_reg < tol_reg))
                        close_next = 1'b1;
                    if (s_tlast && !inside_reg && active)
                        close_next = 1'b1;
                    if (s_tlast || (inside_reg && !active && ci_reg >= tol_reg))
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (close_reg)
                begin
                    inside_next = 1'b0;
                    ci_next     = '0;
                end
                if (bout_ok)
                begin
                    bcnt_next  = sat_inc(bcnt_reg);
                    btime_next = sat_cnt(btime_reg, {1'b0, span_reg});
                    state_next = ST_DIV;
                end
                else if (rend_reg)
                begin
                    mvalid_next = 1'b1;
                    mkind_next  = KIND_SUMMARY;
                    mlast_next  = 1'b1;
                    mdata_next  = {5'd0, bcnt_reg, btime_reg, atot_reg, 108'd0};
                    state_next  = ST_SUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    mvalid_next = 1'b1;
                    mkind_next  = KIND_BOUT;
                    mlast_next  = !rend_reg;
                    mdata_next  = {5'd0, bcnt_reg, btime_reg, atot_reg, mean,
                                   dal_reg, span_reg, last_ep, start_reg};
                    state_next  = ST_BOUT;
                end
            end
            ST_BOUT:
            begin
                if (m_tready)
                begin
                    if (rend_reg)
                    begin
                        mkind_next = KIND_SUMMARY;
                        mlast_next = 1'b1;
                        mdata_next = {5'd0, bcnt_reg, btime_reg, atot_reg, 108'd0};
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        mvalid_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_SUM:
            begin
                if (m_tready)
                begin
                    mvalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // summary loaded: the record starts over
        if (mkind_next == KIND_SUMMARY && state_next == ST_SUM && state_reg != ST_SUM)
        begin
            idx_next    = '0;
            inside_next = 1'b0;
            start_next  = '0;
            aib_next    = '0;
            span_next   = '0;
            dal_next    = '0;
            rdrop_next  = '0;
            ci_next     = '0;
            sal_next    = '0;
            rsum_next   = '0;
            atot_next   = '0;
            btime_next  = '0;
            bcnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            thr_reg    <= 16'd1952;
            minb_reg   <= 16'd10;
            tol_reg    <= 8'd2;
            pct_reg    <= 1'b0;
            idx_reg    <= '0;
            inside_reg <= 1'b0;
            start_reg  <= '0;
            aib_reg    <= '0;
            span_reg   <= '0;
            dal_reg    <= '0;
            rdrop_reg  <= '0;
            ci_reg     <= '0;
            sal_reg    <= '0;
            rsum_reg   <= '0;
            atot_reg   <= '0;
            btime_reg  <= '0;
            bcnt_reg   <= '0;
            close_reg  <= 1'b0;
            rend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            mdata_reg  <= '0;
            mkind_reg  <= KIND_BOUT;
            mlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            thr_reg    <= thr_next;
            minb_reg   <= minb_next;
            tol_reg    <= tol_next;
            pct_reg    <= pct_next;
            idx_reg    <= idx_next;
            inside_reg <= inside_next;
            start_reg  <= start_next;
            aib_reg    <= aib_next;
            span_reg   <= span_next;
            dal_reg    <= dal_next;
            rdrop_reg  <= rdrop_next;
            ci_reg     <= ci_next;
            sal_reg    <= sal_next;
            rsum_reg   <= rsum_next;
            atot_reg   <= atot_next;
            btime_reg  <= btime_next;
            bcnt_reg   <= bcnt_next;
            close_reg  <= close_next;
            rend_reg   <= rend_next;
            mvalid_reg <= mvalid_next;
            mdata_reg  <= mdata_next;
            mkind_reg  <= mkind_next;
            mlast_reg  <= mlast_next;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import abd_pkg::*;

    localparam logic [IDX_W:0] CNT_CAP = 22'd1048576;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  first_ep;
        logic [IDX_W-1:0]  last_ep;
        logic [IDX_W-1:0]  span;
        logic [IDX_W-1:0]  drops;
        logic [MEAN_W-1:0] mean;
        logic [IDX_W-1:0]  tot_active;
        logic [IDX_W-1:0]  tot_time;
        logic [IDX_W-1:0]  tot_bouts;
        logic              run_end;
    } bout_rec_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    // register copies
    logic [15:0] thr_cfg;
    logic [15:0] min_len_cfg;
    logic [7:0]  drop_tol_cfg;
    logic        pct_cfg;

    // per-record state
    logic [IDX_W-1:0] ep_idx;
    logic             in_bout;
    logic [IDX_W-1:0] start_ep;
    logic [IDX_W-1:0] bout_active;
    logic [IDX_W-1:0] span_last;
    logic [IDX_W-1:0] drops_last;
    logic [IDX_W-1:0] run_drops;
    logic [7:0]       gap_run;
    logic [SUM_W-1:0] sum_last;
    logic [SUM_W-1:0] run_sum;
    logic [IDX_W-1:0] act_total;
    logic [IDX_W-1:0] bout_time;
    logic [IDX_W-1:0] bout_cnt;

    bout_rec_t step_recs[$];
    bout_rec_t pending_recs[$];

    int errors = 0;
    int n_epochs = 0;
    int n_bout_recs = 0;
    int n_summaries = 0;
    int cycles = 0;
    int hold_left;
    logic hold_done;
    logic hold_req = 1'b0;
    logic no_idle = 1'b0;

    activity_bout_detector_with_drops u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [IDX_W-1:0] sat_cnt(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > CNT_CAP) ? CNT_CAP[IDX_W-1:0] : s[IDX_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [15:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    task automatic clear_record();
        ep_idx = '0;
        in_bout = 1'b0;
        start_ep = '0;
        bout_active = '0;
        span_last = '0;
        drops_last = '0;
        run_drops = '0;
        gap_run = '0;
        sum_last = '0;
        run_sum = '0;
        act_total = '0;
        bout_time = '0;
        bout_cnt = '0;
    endtask

    task automatic close_bout();
        bout_rec_t rec;
        logic ok;
        logic [23:0] act5;
        logic [23:0] span4;
        logic [IDX_W:0] last_ep;
        logic [DIVD_W-1:0] q;
        ok = bout_active >= IDX_W'(min_len_cfg);
        in_bout = 1'b0;
        gap_run = '0;
        act5 = bout_active * 24'd5;
        span4 = span_last * 24'd4;
        if (pct_cfg && act5 < span4)
            ok = 1'b0;
        if (!ok || span_last == '0)
            return;
        bout_cnt = sat_cnt(bout_cnt, IDX_W'(1));
        bout_time = sat_cnt(bout_time, span_last);
        last_ep = {1'b0, start_ep} + {1'b0, span_last} - 22'd1;
        if (last_ep > CNT_CAP)
            last_ep = CNT_CAP;
        q = {sum_last, 8'd0} / span_last;
        rec = '0;
        rec.kind = KIND_BOUT;
        rec.first_ep = start_ep;
        rec.last_ep = last_ep[IDX_W-1:0];
        rec.span = span_last;
        rec.drops = drops_last;
        rec.mean = (q > 24'hFFFFFF) ? 24'hFFFFFF : q[MEAN_W-1:0];
        rec.tot_active = act_total;
        rec.tot_time = bout_time;
        rec.tot_bouts = bout_cnt;
        step_recs = {step_recs, rec};
    endtask

    // expected results of one accepted epoch
    task automatic predict_bouts(input logic [15:0] count, input logic missing,
                                 input logic rec_end);
        logic active;
        bout_rec_t rec;
        active = !missing && count >= thr_cfg;
        step_recs.delete();
        ep_idx = sat_cnt(ep_idx, IDX_W'(1));
        if (active)
            act_total = sat_cnt(act_total, IDX_W'(1));
        if (in_bout)
        begin
            if (active)
            begin
                bout_active = sat_cnt(bout_active, IDX_W'(1));
                span_last = sat_cnt(span_last, {13'd0, gap_run} + 21'd1);
                run_sum = sat_sum(run_sum, count);
                sum_last = run_sum;
                drops_last = run_drops;
                gap_run = '0;
            end
            else if (gap_run < drop_tol_cfg)
            begin
                gap_run = gap_run + 8'd1;
                run_drops = sat_cnt(run_drops, IDX_W'(1));
                if (!missing)
                    run_sum = sat_sum(run_sum, count);
            end
            else
            begin
                close_bout();
            end
        end
        else if (active)
        begin
            in_bout = 1'b1;
            start_ep = ep_idx;
            bout_active = IDX_W'(1);
            span_last = IDX_W'(1);
            drops_last = '0;
            run_drops = '0;
            gap_run = '0;
            run_sum = SUM_W'(count);
            sum_last = SUM_W'(count);
        end
        if (rec_end)
        begin
            if (in_bout)
                close_bout();
            rec = '0;
            rec.kind = KIND_SUMMARY;
            rec.tot_active = act_total;
            rec.tot_time = bout_time;
            rec.tot_bouts = bout_cnt;
            step_recs = {step_recs, rec};
            clear_record();
        end
        if (step_recs.size() > 0)
            step_recs[step_recs.size() - 1].run_end = 1'b1;
        pending_recs = {pending_recs, step_recs};
    endtask

    task automatic report(input string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [MEAN_W-1:0] got,
                                 input logic [MEAN_W-1:0] want);
        if (got !== want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_result
        bout_rec_t got;
        bout_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser[0];
            got.first_ep = m_tdata[20:0];
            got.last_ep = m_tdata[41:21];
            got.span = m_tdata[62:42];
            got.drops = m_tdata[83:63];
            got.mean = m_tdata[107:84];
            got.tot_active = m_tdata[128:108];
            got.tot_time = m_tdata[149:129];
            got.tot_bouts = m_tdata[170:150];
            got.run_end = m_tlast;
            if (pending_recs.size() == 0)
            begin
                report("result with nothing expected");
            end
            else
            begin
                want = pending_recs.pop_front();
                if (want.kind == KIND_SUMMARY)
                    n_summaries++;
                else
                    n_bout_recs++;
                compare_field("record_kind", MEAN_W'(got.kind), MEAN_W'(want.kind));
                compare_field("bout_first_epoch", MEAN_W'(got.first_ep),
                              MEAN_W'(want.first_ep));
                compare_field("bout_last_epoch", MEAN_W'(got.last_ep),
                              MEAN_W'(want.last_ep));
                compare_field("bout_span", MEAN_W'(got.span), MEAN_W'(want.span));
                compare_field("bout_drop_epochs", MEAN_W'(got.drops), MEAN_W'(want.drops));
                compare_field("bout_mean_count", got.mean, want.mean);
                compare_field("active_epoch_total", MEAN_W'(got.tot_active),
                              MEAN_W'(want.tot_active));
                compare_field("bout_time_total", MEAN_W'(got.tot_time),
                              MEAN_W'(want.tot_time));
                compare_field("valid_bout_total", MEAN_W'(got.tot_bouts),
                              MEAN_W'(want.tot_bouts));
                compare_field("last_of_run", MEAN_W'(got.run_end), MEAN_W'(want.run_end));
            end
        end
    end

    // receiver: random stalls, or one long hold-off once requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_epoch(input logic [15:0] count, input logic missing,
                              input logic rec_end);
        if (!no_idle && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= count;
        s_tuser <= missing;
        s_tlast <= rec_end;
        do @(posedge clk); while (!s_tready);
        predict_bouts(count, missing, rec_end);
        n_epochs++;
    endtask

    // active or inactive epoch with random content, now and then pure noise
    task automatic send_shaped(input logic want_active, input logic rec_end);
        logic [15:0] c;
        logic miss;
        c = 16'($urandom);
        miss = 1'b0;
        if ($urandom_range(99) < 8)
            miss = 1'($urandom_range(1));
        else if (want_active)
            c = 16'($urandom_range(65535, thr_cfg));
        else if (thr_cfg == 0 || $urandom_range(1) == 1)
            miss = 1'b1;
        else
            c = 16'($urandom_range(thr_cfg - 1, 0));
        send_epoch(c, miss, rec_end);
    endtask

    // whole records of active runs and drop gaps, some gaps past the tolerance
    task automatic send_records(input int n_items, input int max_len);
        int goal;
        int len;
        int pos;
        int run;
        int gap;
        goal = n_epochs + n_items;
        while (n_epochs < goal)
        begin
            len = $urandom_range(1, max_len);
            pos = 0;
            while (pos < len)
            begin
                if ($urandom_range(3) == 0)
                    gap = drop_tol_cfg + 1 + $urandom_range(2);
                else if (drop_tol_cfg > 8 && $urandom_range(7) != 0)
                    gap = $urandom_range(8);
                else
                    gap = $urandom_range(drop_tol_cfg);
                if (pos == 0 && $urandom_range(1) == 0)
                    gap = 0;
                for (int k = 0; k < gap && pos < len; k++)
                begin
                    pos++;
                    send_shaped(1'b0, pos == len);
                end
                run = $urandom_range(1, 16);
                for (int k = 0; k < run && pos < len; k++)
                begin
                    pos++;
                    send_shaped(1'b1, pos == len);
                end
            end
        end
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_recs.size() != 0);
    endtask

    task automatic settle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_cfg = val;
            REG_MIN_BOUT:  min_len_cfg = val;
            REG_DROP_TOL:  drop_tol_cfg = val[7:0];
            REG_PERCENT:   pct_cfg = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] thr, input logic [15:0] min_len,
                             input logic [7:0] drop_tol, input logic pct);
        settle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MIN_BOUT, min_len);
        write_reg(REG_DROP_TOL, {8'd0, drop_tol});
        write_reg(REG_PERCENT, {15'd0, pct});
    endtask

    // reset values of the registers
    task automatic test_directed_defaults();
        send_epoch(16'hFFFF, 1'b0, 1'b0);
        send_epoch(16'd1952, 1'b0, 1'b0);
        send_epoch(16'd0, 1'b0, 1'b0);
        send_epoch(16'hFFFF, 1'b1, 1'b0);
        repeat (8) send_epoch(16'($urandom_range(65535, 1952)), 1'b0, 1'b0);
        repeat (2) send_epoch(16'd1951, 1'b0, 1'b0);
        // closing epoch that also ends the record
        send_epoch(16'd7, 1'b1, 1'b1);
    endtask

    task automatic test_directed_edges();
        // zero threshold and zero length, no drops allowed
        configure(16'd0, 16'd0, 8'd0, 1'b1);
        send_epoch(16'd0, 1'b0, 1'b0);
        send_epoch(16'd5, 1'b1, 1'b0);
        // percent rule fails, then passes with trailing drop trimmed at record end
        configure(16'd100, 16'd0, 8'd2, 1'b1);
        send_epoch(16'd100, 1'b0, 1'b0);
        send_epoch(16'd0, 1'b1, 1'b0);
        send_epoch(16'd0, 1'b1, 1'b0);
        send_epoch(16'hFFFF, 1'b0, 1'b0);
        send_epoch(16'd0, 1'b1, 1'b0);
        send_epoch(16'd0, 1'b1, 1'b0);
        send_epoch(16'd99, 1'b0, 1'b0);
        repeat (4) send_epoch(16'($urandom_range(65535, 100)), 1'b0, 1'b0);
        send_epoch(16'd99, 1'b0, 1'b0);
        send_epoch(16'd4000, 1'b0, 1'b0);
        send_epoch(16'd99, 1'b0, 1'b1);
    endtask

    task automatic test_random_sweep();
        for (int i = 0; i < 8; i++)
        begin
            case (i)
                0: configure(16'd0, 16'd1, 8'd0, 1'b0);
                1: configure(16'hFFFF, 16'd1, 8'd1, 1'b1);
                2: configure(16'($urandom), 16'hFFFF, 8'd255, 1'b0);
                3: configure(16'($urandom), 16'd0, 8'd255, 1'b1);
                default: configure(16'($urandom_range(65535)), 16'($urandom_range(1, 12)),
                                   8'($urandom_range(6)), 1'($urandom_range(1)));
            endcase
            send_records((i == 2) ? 60 : 130, 80);
        end
    endtask

    task automatic test_output_backpressure();
        configure(16'd1000, 16'd1, 8'd2, 1'b0);
        no_idle = 1'b1;
        hold_req = 1'b1;
        send_records(200, 40);
        no_idle = 1'b0;
    endtask

    task automatic test_sender_pause();
        configure(16'($urandom_range(4000)), 16'($urandom_range(1, 6)),
                  8'($urandom_range(4)), 1'b0);
        send_records(100, 60);
        wait_results_done();
        send_records(100, 60);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        s_tlast <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_THRESHOLD;
        cfg_data <= '0;
        thr_cfg = 16'd1952;
        min_len_cfg = 16'd10;
        drop_tol_cfg = 8'd2;
        pct_cfg = 1'b0;
        clear_record();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_defaults();
        test_directed_edges();
        test_random_sweep();
        test_output_backpressure();
        test_sender_pause();
        settle();

        $display("covered %0d epochs; checked %0d bout records and %0d record summaries",
                 n_epochs, n_bout_recs, n_summaries);
        $display("settings swept across threshold, minimum length, drop tolerance "
                 , "and the percent rule, with output hold-off and input pauses");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
